// ===== rtl/record_sort_by_duration_assert.svh =====
// Assertion macros shared by the record sorter RTL.
`ifndef RECORD_SORT_BY_DURATION_ASSERT_SVH
`define RECORD_SORT_BY_DURATION_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define RSD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rsd_pkg.sv =====
// Package with types and constants for the record sorter.
package rsd_pkg;

  localparam int CAPACITY = 64;

  localparam int HOURS_W = 10;
  localparam int TAG_W   = 16;
  localparam int RATE_W  = 16;
  localparam int FEE_W   = 26;

  localparam logic [RATE_W-1:0] CAR_RATE_RESET  = RATE_W'(4000);
  localparam logic [RATE_W-1:0] MOTO_RATE_RESET = RATE_W'(2000);

  typedef enum logic {
    CFG_CAR_RATE  = 1'b0,
    CFG_MOTO_RATE = 1'b1
  } cfg_index_t;

  typedef logic [CAPACITY-1:0] cell_vec_t;

  typedef struct packed {
    logic [HOURS_W-1:0] hours;
    logic [TAG_W-1:0]   tag;
    logic               kind;
  } record_t;

  typedef struct packed {
    logic load;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== rtl/rsd_cell.sv =====
// One cell of the sorted insertion chain.
module rsd_cell (
  input  logic                clk,
  input  logic                rst,
  input  rsd_pkg::cell_ctrl_t ctrl,
  input  rsd_pkg::record_t    new_rec,
  input  rsd_pkg::record_t    left_rec,
  input  logic                left_valid,
  input  logic                left_gt,
  input  rsd_pkg::record_t    right_rec,
  input  logic                right_valid,
  output rsd_pkg::record_t    rec,
  output logic                valid,
  output logic                gt
);
  import rsd_pkg::*;

  logic take;

  // Greater keys move right; equal keys stay ahead of the new item.
  assign gt   = valid && (rec.hours > new_rec.hours);
  assign take = gt || (!valid && left_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end else if (ctrl.load && take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rec <= right_rec;
    end else if (ctrl.load && take) begin
      rec <= left_gt ? left_rec : new_rec;
    end
  end

endmodule

// ===== rtl/rsd_emit.sv =====
// Output register stage that computes the fee of each emitted item.
module rsd_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop,
  input  rsd_pkg::record_t               head,
  input  logic                           head_final,
  input  logic                           run_dropped,
  input  logic [rsd_pkg::RATE_W-1:0]     car_rate,
  input  logic [rsd_pkg::RATE_W-1:0]     motorcycle_rate,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [rsd_pkg::HOURS_W-1:0]    out_hours,
  output logic [rsd_pkg::TAG_W-1:0]      out_tag,
  output logic                           out_vehicle_kind,
  output logic [rsd_pkg::FEE_W-1:0]      fee,
  output logic                           final_item,
  output logic                           dropped
);
  import rsd_pkg::*;

  logic [RATE_W-1:0] rate;
  logic [FEE_W-1:0]  fee_next;

  assign rate     = head.kind ? motorcycle_rate : car_rate;
  assign fee_next = FEE_W'(head.hours) * FEE_W'(rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_hours        <= head.hours;
      out_tag          <= head.tag;
      out_vehicle_kind <= head.kind;
      fee              <= fee_next;
      final_item       <= head_final;
      dropped          <= run_dropped;
    end
  end

endmodule

// ===== rtl/record_sort_by_duration.sv =====
// Top level of the record sorter: insertion chain, control and configuration.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_stall, hours..last_item      into block
//   out      out_valid, out_stall, out_hours..dropped  out of block
//   cfg      cfg_write, cfg_index, cfg_data            into block
//
// Each accepted item is placed into the chain of cells unless the chain is full.
// On the item marked last, the chain drains one item per cycle, while the
// output is not stalled, into the output register; in_stall is high for the
// whole drain.
// Reset clears the cell valid bits and the drain flag and loads the default rates.
// A stall on the output holds the drain in place without losing an item.
module record_sort_by_duration (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rsd_pkg::HOURS_W-1:0]    hours,
  input  logic [rsd_pkg::TAG_W-1:0]      record_tag,
  input  logic                           vehicle_kind,
  input  logic                           last_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rsd_pkg::HOURS_W-1:0]    out_hours,
  output logic [rsd_pkg::TAG_W-1:0]      out_tag,
  output logic                           out_vehicle_kind,
  output logic [rsd_pkg::FEE_W-1:0]      fee,
  output logic                           final_item,
  output logic                           dropped,
  input  logic                           cfg_write,
  input  rsd_pkg::cfg_index_t            cfg_index,
  input  logic [rsd_pkg::RATE_W-1:0]     cfg_data
);
  import rsd_pkg::*;

  `include "record_sort_by_duration_assert.svh"

  logic              draining;
  logic              overflow_seen;
  logic              run_dropped;
  logic [RATE_W-1:0] car_rate;
  logic [RATE_W-1:0] motorcycle_rate;

  record_t    new_rec;
  record_t    cell_rec   [CAPACITY];
  cell_vec_t  valid_vec;
  cell_vec_t  gt_vec;
  cell_ctrl_t ctrl;
  logic       in_accept;
  logic       full;
  logic       pop;

  assign in_stall  = draining;
  assign in_accept = in_valid && !in_stall;
  assign full      = valid_vec[CAPACITY-1];
  assign pop       = draining && valid_vec[0] && (!out_valid || !out_stall);
  assign ctrl      = '{load: in_accept && !full, pop: pop};
  assign new_rec   = '{hours: hours, tag: record_tag, kind: vehicle_kind};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    record_t left_rec;
    logic    left_valid;
    logic    left_gt;
    record_t right_rec;
    logic    right_valid;

    if (i == 0) begin : g_first
      assign left_rec   = new_rec;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_inner_left
      assign left_rec   = cell_rec[i-1];
      assign left_valid = valid_vec[i-1];
      assign left_gt    = gt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_rec   = new_rec;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_rec   = cell_rec[i+1];
      assign right_valid = valid_vec[i+1];
    end

    rsd_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_rec     (new_rec),
      .left_rec    (left_rec),
      .left_valid  (left_valid),
      .left_gt     (left_gt),
      .right_rec   (right_rec),
      .right_valid (right_valid),
      .rec         (cell_rec[i]),
      .valid       (valid_vec[i]),
      .gt          (gt_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining      <= 1'b0;
      overflow_seen <= 1'b0;
      run_dropped   <= 1'b0;
    end else if (in_accept) begin
      if (last_item) begin
        draining      <= 1'b1;
        run_dropped   <= overflow_seen || full;
        overflow_seen <= 1'b0;
      end else if (full) begin
        overflow_seen <= 1'b1;
      end
    end else if (pop && !valid_vec[1]) begin
      draining <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      car_rate        <= CAR_RATE_RESET;
      motorcycle_rate <= MOTO_RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CAR_RATE:  car_rate        <= cfg_data;
        CFG_MOTO_RATE: motorcycle_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  rsd_emit u_emit (
    .clk              (clk),
    .rst              (rst),
    .pop              (pop),
    .head             (cell_rec[0]),
    .head_final       (!valid_vec[1]),
    .run_dropped      (run_dropped),
    .car_rate         (car_rate),
    .motorcycle_rate  (motorcycle_rate),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_hours        (out_hours),
    .out_tag          (out_tag),
    .out_vehicle_kind (out_vehicle_kind),
    .fee              (fee),
    .final_item       (final_item),
    .dropped          (dropped)
  );

  `RSD_ASSERT_ALWAYS(a_valid_packed, (valid_vec & cell_vec_t'(valid_vec + 1'b1)) == '0,
    "Cell valid bits are not packed toward the head.")
  `RSD_ASSERT_ALWAYS(a_drain_has_head, !draining || valid_vec[0],
    "Draining with an empty head cell.")
  `RSD_ASSERT_NEXT(a_final_empties, pop && !valid_vec[1], valid_vec == '0 && !draining,
    "Chain not empty after the final item was emitted.")
  `RSD_ASSERT_NEXT(a_last_drains, in_accept && last_item, draining && valid_vec[0],
    "Last item did not start the drain.")

endmodule

// ===== verif/record_sort_by_duration_checker.sv =====
// Checker that tracks rates, predicts each sorted run and compares every output item.
module record_sort_by_duration_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rsd_pkg::HOURS_W-1:0]  hours,
  input  logic [rsd_pkg::TAG_W-1:0]    record_tag,
  input  logic                         vehicle_kind,
  input  logic                         last_item,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rsd_pkg::HOURS_W-1:0]  out_hours,
  input  logic [rsd_pkg::TAG_W-1:0]    out_tag,
  input  logic                         out_vehicle_kind,
  input  logic [rsd_pkg::FEE_W-1:0]    fee,
  input  logic                         final_item,
  input  logic                         dropped,
  input  logic                         cfg_write,
  input  rsd_pkg::cfg_index_t          cfg_index,
  input  logic [rsd_pkg::RATE_W-1:0]   cfg_data,
  output int                           pending,
  output int                           fail_count,
  output int                           checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import rsd_pkg::*;

  typedef struct {
    logic [HOURS_W-1:0] hours;
    logic [TAG_W-1:0]   tag;
    logic               kind;
    logic [FEE_W-1:0]   fee;
    logic               final_flag;
    logic               dropped_flag;
  } billed_record_t;

  record_t            run_list [CAPACITY];
  int                 run_len;
  logic               run_overflow;
  logic [RATE_W-1:0]  car_rate;
  logic [RATE_W-1:0]  moto_rate;
  billed_record_t     due_records [$];

  initial begin
    pending = 0;
    fail_count = 0;
    checked = 0;
  end

  task automatic file_record(record_t rec);
    int pos;
    if (run_len >= CAPACITY) begin
      run_overflow = 1'b1;
      return;
    end
    pos = run_len;
    while (pos > 0 && run_list[pos-1].hours > rec.hours) begin
      run_list[pos] = run_list[pos-1];
      pos--;
    end
    run_list[pos] = rec;
    run_len++;
  endtask

  task automatic bill_sorted_run();
    billed_record_t due;
    logic [RATE_W-1:0] rate;
    for (int k = 0; k < run_len; k++) begin
      rate = run_list[k].kind ? moto_rate : car_rate;
      due.hours = run_list[k].hours;
      due.tag = run_list[k].tag;
      due.kind = run_list[k].kind;
      due.fee = FEE_W'(32'(run_list[k].hours) * 32'(rate));
      due.final_flag = (k == run_len - 1);
      due.dropped_flag = run_overflow;
      due_records.push_back(due);
    end
    run_len = 0;
    run_overflow = 1'b0;
  endtask

  task automatic match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    billed_record_t head;
    if (rst) begin
      car_rate = CAR_RATE_RESET;
      moto_rate = MOTO_RATE_RESET;
      run_len = 0;
      run_overflow = 1'b0;
      due_records.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CAR_RATE: car_rate = cfg_data;
          CFG_MOTO_RATE: moto_rate = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_records.size() == 0) begin
          $error("Output item with tag %0d arrived with nothing expected.", out_tag);
          fail_count++;
        end else begin
          head = due_records.pop_front();
          match_field("out_hours", 32'(head.hours), 32'(out_hours));
          match_field("out_tag", 32'(head.tag), 32'(out_tag));
          match_field("out_vehicle_kind", 32'(head.kind), 32'(out_vehicle_kind));
          match_field("fee", 32'(head.fee), 32'(fee));
          match_field("final_item", 32'(head.final_flag), 32'(final_item));
          match_field("dropped", 32'(head.dropped_flag), 32'(dropped));
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        file_record({hours, record_tag, vehicle_kind});
        if (last_item) begin
          bill_sorted_run();
        end
      end
    end
    pending = due_records.size();
  end

endmodule

// ===== verif/record_sort_by_duration_tb.sv =====
// Testbench top for the record sorter: clock, reset, stimulus, output stalls and verdict.
module record_sort_by_duration_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsd_pkg::*;

  localparam int LONG_HOLD = 150;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [HOURS_W-1:0] hours = '0;
  logic [TAG_W-1:0]   record_tag = '0;
  logic               vehicle_kind = 1'b0;
  logic               last_item = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [HOURS_W-1:0] out_hours;
  logic [TAG_W-1:0]   out_tag;
  logic               out_vehicle_kind;
  logic [FEE_W-1:0]   fee;
  logic               final_item;
  logic               dropped;
  logic               cfg_write = 1'b0;
  cfg_index_t         cfg_index = CFG_CAR_RATE;
  logic [RATE_W-1:0]  cfg_data = '0;

  int pending;
  int fail_count;
  int checked;

  int items_sent = 0;
  int runs_sent = 0;
  bit tx_random = 1'b1;
  bit rx_random = 1'b1;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int burst_cnt = 0;

  always #2 clk = ~clk;

  record_sort_by_duration u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .hours            (hours),
    .record_tag       (record_tag),
    .vehicle_kind     (vehicle_kind),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hours        (out_hours),
    .out_tag          (out_tag),
    .out_vehicle_kind (out_vehicle_kind),
    .fee              (fee),
    .final_item       (final_item),
    .dropped          (dropped),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  record_sort_by_duration_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .hours            (hours),
    .record_tag       (record_tag),
    .vehicle_kind     (vehicle_kind),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hours        (out_hours),
    .out_tag          (out_tag),
    .out_vehicle_kind (out_vehicle_kind),
    .fee              (fee),
    .final_item       (final_item),
    .dropped          (dropped),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pending          (pending),
    .fail_count       (fail_count),
    .checked          (checked)
  );

  always @(negedge clk) begin
    logic nxt;
    if (hold_req && hold_cnt == 0) begin
      hold_cnt = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_cnt != 0) begin
      nxt = 1'b1;
      hold_cnt--;
    end else if (burst_cnt != 0) begin
      nxt = 1'b1;
      burst_cnt--;
    end else if (rx_random && $urandom_range(0, 5) == 0) begin
      burst_cnt = $urandom_range(0, 2);
      nxt = 1'b1;
    end else begin
      nxt = 1'b0;
    end
    out_stall <= nxt;
  end

  task automatic send_item(logic [HOURS_W-1:0] h, logic [TAG_W-1:0] t, logic k, logic lst);
    if (tx_random && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    hours <= h;
    record_tag <= t;
    vehicle_kind <= k;
    last_item <= lst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (lst) runs_sent++;
  endtask

  function automatic logic [HOURS_W-1:0] pick_hours();
    case ($urandom_range(0, 3))
      0: return HOURS_W'($urandom_range(0, 7));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return HOURS_W'($urandom);
    endcase
  endfunction

  task automatic send_run(int len, bit hold_on_last);
    for (int i = 0; i < len; i++) begin
      if (hold_on_last && i == len - 1) hold_req = 1'b1;
      send_item(pick_hours(), TAG_W'($urandom), 1'($urandom), i == len - 1);
    end
  endtask

  task automatic short_runs(int budget);
    int used = 0;
    int len;
    while (used < budget) begin
      len = $urandom_range(1, 8);
      send_run(len, 1'b0);
      used += len;
    end
  endtask

  // Lets the last run drain completely so the rates can change safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_rates(logic [RATE_W-1:0] car, logic [RATE_W-1:0] moto);
    cfg_write <= 1'b1;
    cfg_index <= CFG_CAR_RATE;
    cfg_data <= car;
    @(negedge clk);
    cfg_index <= CFG_MOTO_RATE;
    cfg_data <= moto;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(10'd0, 16'd0, 1'b0, 1'b1);
    send_item(10'd1023, 16'hFFFF, 1'b1, 1'b0);
    send_item(10'd0, 16'd1, 1'b0, 1'b0);
    send_item(10'd5, 16'd2, 1'b1, 1'b0);
    send_item(10'd5, 16'd3, 1'b0, 1'b0);
    send_item(10'd1023, 16'd4, 1'b0, 1'b0);
    send_item(10'd5, 16'd5, 1'b1, 1'b1);
    for (int i = 0; i < 7; i++) begin
      send_item(HOURS_W'(9 - i), TAG_W'(16 + i), i[0], i == 6);
    end
    for (int i = 0; i < 4; i++) begin
      send_item(HOURS_W'(100 * i), TAG_W'(32 + i), ~i[0], i == 3);
    end
    settle();

    set_rates(16'hFFFF, 16'h0000);
    short_runs(3);
    settle();

    set_rates(16'h0000, 16'hFFFF);
    send_run(CAPACITY, 1'b1);
    short_runs(2);
    settle();

    set_rates(RATE_W'($urandom), RATE_W'($urandom));
    send_run(CAPACITY + 3, 1'b0);
    short_runs(2);
    settle();

    set_rates(16'hFFFF, 16'hFFFF);
    short_runs(3);
    settle();

    tx_random = 1'b0;
    rx_random = 1'b0;
    set_rates(RATE_W'($urandom), RATE_W'($urandom));
    short_runs(3);
    settle();

    $display("Sent %0d items in %0d runs; %0d sorted records checked under six rate settings.",
             items_sent, runs_sent, checked);
    $display("Covered ties, a full run, an overflow run ending on a discarded item %s",
             "and a long output hold.");
    if (fail_count == 0) begin
      $display("record_sort_by_duration test passed");
    end else begin
      $display("record_sort_by_duration test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timeout with %0d output items still expected.", pending);
    $display("record_sort_by_duration test failed");
    $finish;
  end

endmodule
